// File: rtl/core/pctx_pkg.sv
// Shared types, codes and character helpers for the hex-escape codec.
package pctx_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned CNT_W    = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR = 8'd1;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h25;  // '%'

  // Escape capture phases
  localparam logic [1:0] ESC_IDLE   = 2'd0;
  localparam logic [1:0] ESC_FIRST  = 2'd1;
  localparam logic [1:0] ESC_SECOND = 2'd2;

  // Marks a byte that is not a hex digit
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef logic [BYTE_W-1:0] byte_t;

  // Result set produced for one request: up to three bytes, in order
  typedef struct packed {
    byte_t [MAX_RES-1:0] bytes;   // bytes[0] goes out first
    logic  [CNT_W-1:0]   count;
    logic                last;    // applies to the final byte of the set
  } res_set_t;

  function automatic logic byte_is_safe(input byte_t c);
    logic alnum;
    logic mark;
    alnum = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39);
    mark  = (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) || (c == 8'h21) ||
            (c == 8'h7E) || (c == 8'h2A) || (c == 8'h27) || (c == 8'h28) ||
            (c == 8'h29);
    return alnum || mark;
  endfunction

  // Digit value 0..15, or HEX_NONE
  function automatic logic [4:0] hex_value(input byte_t c);
    byte_t d;
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      v = {1'b0, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      v = {1'b0, d[3:0]};
    end
    return v;
  endfunction

  function automatic byte_t hex_char(input logic [3:0] nib);
    byte_t r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'b0, nib};
    end else begin
      r = 8'h37 + {4'b0, nib};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pctx_if.sv
// Channel interfaces: input bytes, result bytes and configuration writes.
interface pctx_in_if;
  logic                  valid;
  logic                  ready;
  logic [pctx_pkg::BYTE_W-1:0] data_byte;
  logic                  last;
  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface pctx_out_if;
  logic                  valid;
  logic                  ready;
  logic [pctx_pkg::BYTE_W-1:0] out_byte;
  logic                  out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface pctx_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [pctx_pkg::CFG_IDX_W-1:0] index;
  logic [pctx_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/pctx_codec.sv
// Configuration registers, escape capture state and per-byte result logic.
module pctx_codec (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_take,
  input  logic [pctx_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last,
  input  logic                           cfg_we,
  input  logic [pctx_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pctx_pkg::CFG_DAT_W-1:0] cfg_dat,
  output pctx_pkg::res_set_t             res
);

  logic                        decode_mode_r, decode_mode_nxt;
  logic [pctx_pkg::BYTE_W-1:0] escape_char_r, escape_char_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic [pctx_pkg::BYTE_W-1:0] accum_r, accum_nxt;
  logic                        stopped_r, stopped_nxt;

  logic [4:0]                  hv;
  logic                        digit_ok;
  logic [pctx_pkg::BYTE_W-1:0] acc_upd;

  assign hv       = pctx_pkg::hex_value(data_byte);
  assign digit_ok = (hv != pctx_pkg::HEX_NONE) && !stopped_r;

  always_comb begin
    res             = '0;
    phase_nxt       = phase_r;
    accum_nxt       = accum_r;
    stopped_nxt     = stopped_r;
    decode_mode_nxt = decode_mode_r;
    escape_char_nxt = escape_char_r;
    acc_upd         = accum_r;

    if (!decode_mode_r) begin
      res.last = last;
      if (pctx_pkg::byte_is_safe(data_byte)) begin
        res.bytes[0] = data_byte;
        res.count    = 2'd1;
      end else begin
        res.bytes[0] = escape_char_r;
        res.bytes[1] = pctx_pkg::hex_char(data_byte[7:4]);
        res.bytes[2] = pctx_pkg::hex_char(data_byte[3:0]);
        res.count    = 2'd3;
      end
    end else begin
      res.last = last;
      unique case (phase_r)
        pctx_pkg::ESC_IDLE: begin
          if (data_byte != escape_char_r) begin
            res.bytes[0] = data_byte;
            res.count    = 2'd1;
          end else if (last) begin
            res.bytes[0] = '0;
            res.count    = 2'd1;
          end else begin
            res.count    = 2'd0;
          end
        end
        pctx_pkg::ESC_FIRST: begin
          acc_upd = digit_ok ? {4'b0, hv[3:0]} : accum_r;
          res.bytes[0] = acc_upd;
          res.count    = last ? 2'd1 : 2'd0;
        end
        default: begin
          acc_upd = digit_ok ? {accum_r[3:0], hv[3:0]} : accum_r;
          res.bytes[0] = acc_upd;
          res.count    = 2'd1;
        end
      endcase
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        pctx_pkg::REG_DECODE_MODE: decode_mode_nxt = cfg_dat[0];
        pctx_pkg::REG_ESCAPE_CHAR: escape_char_nxt = cfg_dat;
        default: ;
      endcase
      if (cfg_idx == pctx_pkg::REG_DECODE_MODE || cfg_idx == pctx_pkg::REG_ESCAPE_CHAR) begin
        phase_nxt   = pctx_pkg::ESC_IDLE;
        accum_nxt   = '0;
        stopped_nxt = 1'b0;
      end
    end else if (req_take) begin
      if (!decode_mode_r) begin
        phase_nxt   = pctx_pkg::ESC_IDLE;
        accum_nxt   = '0;
        stopped_nxt = 1'b0;
      end else begin
        unique case (phase_r)
          pctx_pkg::ESC_IDLE: begin
            accum_nxt   = '0;
            stopped_nxt = 1'b0;
            phase_nxt   = (data_byte == escape_char_r && !last) ?
                          pctx_pkg::ESC_FIRST : pctx_pkg::ESC_IDLE;
          end
          pctx_pkg::ESC_FIRST: begin
            if (last) begin
              phase_nxt   = pctx_pkg::ESC_IDLE;
              accum_nxt   = '0;
              stopped_nxt = 1'b0;
            end else begin
              phase_nxt   = pctx_pkg::ESC_SECOND;
              accum_nxt   = acc_upd;
              stopped_nxt = stopped_r || !digit_ok;
            end
          end
          default: begin
            phase_nxt   = pctx_pkg::ESC_IDLE;
            accum_nxt   = '0;
            stopped_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      escape_char_r <= pctx_pkg::ESCAPE_RESET;
      phase_r       <= pctx_pkg::ESC_IDLE;
      accum_r       <= '0;
      stopped_r     <= 1'b0;
    end else begin
      decode_mode_r <= decode_mode_nxt;
      escape_char_r <= escape_char_nxt;
      phase_r       <= phase_nxt;
      accum_r       <= accum_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

// File: rtl/core/pctx_emit.sv
// Result register: holds up to three bytes of one request and sends them in order.
module pctx_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  pctx_pkg::res_set_t          res,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pctx_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last,
  output logic                        can_load
);

  pctx_pkg::byte_t [pctx_pkg::MAX_RES-1:0] buf_r, buf_nxt;
  logic [pctx_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                                    last_r, last_nxt;
  logic                                    take;

  assign out_valid = (cnt_r != '0);
  assign out_byte  = buf_r[0];
  assign out_last  = last_r && (cnt_r == 2'd1);
  assign take      = out_valid && out_ready;
  // free now, or the final byte leaves this cycle
  assign can_load  = (cnt_r == '0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (load) begin
      buf_nxt  = res.bytes;
      cnt_nxt  = res.count;
      last_nxt = res.last;
    end else if (take) begin
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/percent_hex_escape_codec_top.sv
// Hex-escape byte codec: encodes unsafe bytes as escapes or decodes escapes.
//
// Channels: in_ch carries one byte per request with a last flag, out_ch
// returns the encoded or decoded stream with out_last, and cfg_ch writes
// decode_mode (index 0) and escape_char (index 1); cfg_ch is always ready.
// A write to either register drops any escape that is half captured.
// The first result byte of a request shows on out_ch the cycle after the
// request is taken.
// Throughput: one byte per cycle while out_ch is ready. An encoded escape
// holds the result register, and in_ch off, until its last byte leaves; in
// decode mode an escape byte and its first digit give no output unless flagged last.
// in_ready is high when the result register is empty or its last byte is
// being taken that cycle, so a new request overlaps the final output beat.
// When out_ch stalls, the held byte stays and in_ch stops while the result
// register holds any byte.
// Reset (rst_n low, synchronous): encode mode, escape '%', no capture in
// progress, result register empty.
module percent_hex_escape_codec_top (
  input  logic           clk,
  input  logic           rst_n,
  pctx_in_if.sink        in_ch,
  pctx_out_if.source     out_ch,
  pctx_cfg_if.sink       cfg_ch
);

  pctx_pkg::res_set_t res;
  logic               can_load;
  logic               req_take;
  logic               cfg_we;

  assign in_ch.ready  = can_load;
  assign req_take     = in_ch.valid && can_load;
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  pctx_codec u_codec (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_take  (req_take),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.last),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_ch.index),
    .cfg_dat   (cfg_ch.data),
    .res       (res)
  );

  pctx_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (req_take),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .can_load  (can_load)
  );

endmodule

// File: rtl/core/pctx_checker.sv
// Port-level checks for the codec top, attached by bind.
module pctx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled result holds its byte and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // no new request while a result is stuck at the output
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while output stalled");

  // reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind percent_hex_escape_codec_top pctx_checker u_pctx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);

// File: tb/testbench.sv
// Self-checking testbench for the hex-escape codec: predicts every result byte and compares.
`timescale 1ns / 100ps

module testbench;

  localparam int IDLE_PCT    = 34;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 10;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_SHOWN   = 40;
  localparam int PHASES      = 7;

  // Scoreboard: tracks codec registers and escape capture, holds the bytes still due.
  class escape_codec_scoreboard;
    typedef struct packed {
      pctx_pkg::byte_t value;
      logic            fin;
    } beat_t;

    bit              mode_decode;
    pctx_pkg::byte_t esc_byte;
    logic [1:0]      phase;
    pctx_pkg::byte_t accum;
    bit              stopped;
    beat_t           due_bytes[$];
    int              errors;
    int              requests;
    int              compared;
    int              writes;

    function new();
      mode_decode = 1'b0;
      esc_byte    = pctx_pkg::ESCAPE_RESET;
      clear_capture();
    endfunction

    function void clear_capture();
      phase   = pctx_pkg::ESC_IDLE;
      accum   = '0;
      stopped = 1'b0;
    endfunction

    function bit is_unreserved(pctx_pkg::byte_t c);
      string marks;
      bit hit;
      marks = "-_.!~*'()";
      hit = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
      for (int i = 0; i < marks.len(); i++) begin
        if (c == pctx_pkg::byte_t'(marks[i])) hit = 1'b1;
      end
      return hit;
    endfunction

    function logic [4:0] digit_value(pctx_pkg::byte_t c);
      logic [4:0] v;
      v = pctx_pkg::HEX_NONE;
      if (c >= "0" && c <= "9") v = 5'(c - "0");
      else if (c >= "A" && c <= "F") v = 5'(c - "A" + 10);
      else if (c >= "a" && c <= "f") v = 5'(c - "a" + 10);
      return v;
    endfunction

    function pctx_pkg::byte_t hex_digit(logic [3:0] nib);
      pctx_pkg::byte_t r;
      if (nib < 4'd10) r = pctx_pkg::byte_t'("0" + nib);
      else r = pctx_pkg::byte_t'("A" + nib - 10);
      return r;
    endfunction

    function void push(pctx_pkg::byte_t b, logic fin);
      beat_t e;
      e.value = b;
      e.fin   = fin;
      due_bytes.push_back(e);
    endfunction

    function void write_register(logic [pctx_pkg::CFG_IDX_W-1:0] idx,
                                 logic [pctx_pkg::CFG_DAT_W-1:0] val);
      writes++;
      if (idx == pctx_pkg::REG_DECODE_MODE) begin
        mode_decode = val[0];
        clear_capture();
      end else if (idx == pctx_pkg::REG_ESCAPE_CHAR) begin
        esc_byte = val;
        clear_capture();
      end
    endfunction

    function void take_request(pctx_pkg::byte_t b, logic fin);
      logic [4:0] d;
      requests++;
      if (!mode_decode) begin
        clear_capture();
        if (is_unreserved(b)) begin
          push(b, fin);
        end else begin
          push(esc_byte, 1'b0);
          push(hex_digit(b[7:4]), 1'b0);
          push(hex_digit(b[3:0]), fin);
        end
      end else begin
        case (phase)
          pctx_pkg::ESC_IDLE: begin
            if (b != esc_byte) begin
              push(b, fin);
            end else if (fin) begin
              // stream ends on the escape itself: value 0
              clear_capture();
              push('0, 1'b1);
            end else begin
              clear_capture();
              phase = pctx_pkg::ESC_FIRST;
            end
          end
          pctx_pkg::ESC_FIRST: begin
            d = digit_value(b);
            if (d != pctx_pkg::HEX_NONE && !stopped) accum = pctx_pkg::byte_t'(d[3:0]);
            else stopped = 1'b1;
            if (fin) begin
              push(accum, 1'b1);
              clear_capture();
            end else begin
              phase = pctx_pkg::ESC_SECOND;
            end
          end
          default: begin
            d = digit_value(b);
            if (d != pctx_pkg::HEX_NONE && !stopped) accum = {accum[3:0], d[3:0]};
            push(accum, fin);
            clear_capture();
          end
        endcase
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_SHOWN) $display("testbench: mismatch: %s", what);
    endtask

    task take_result(pctx_pkg::byte_t b, logic fin);
      beat_t want;
      compared++;
      if (due_bytes.size() == 0) begin
        report($sformatf("byte %02h last %0b with nothing due", b, fin));
      end else begin
        want = due_bytes.pop_front();
        if (b !== want.value)
          report($sformatf("result %0d byte %02h, want %02h", compared, b, want.value));
        if (fin !== want.fin)
          report($sformatf("result %0d last %0b, want %0b", compared, fin, want.fin));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pctx_in_if  in_ch ();
  pctx_out_if out_ch ();
  pctx_cfg_if cfg_ch ();

  percent_hex_escape_codec_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  escape_codec_scoreboard sb = new();

  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  int hold_requests   = 0;
  int sent_count      = 0;
  int stuck_cycles    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitors: requests, result bytes and register writes as they are accepted
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.take_request(in_ch.data_byte, in_ch.last);
    if (rst_n && out_ch.valid && out_ch.ready) sb.take_result(out_ch.out_byte, out_ch.out_last);
    if (rst_n && cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.data);
  end

  // Result side: random stalls, steady stretches, and long hold-offs on request
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (receiver_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("testbench: no progress for %0d cycles", STUCK_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_byte(input pctx_pkg::byte_t b, input logic fin);
    int gap;
    if (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++)
      send_byte(pctx_pkg::byte_t'(s[i]), fin && (i == s.len() - 1));
  endtask

  // Stop offering and wait out every due byte, then let any pending capture settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the monitor note the final request before looking at the queue
    @(posedge clk);
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pctx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pctx_pkg::CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pctx_pkg::byte_t pick_hex_char();
    logic [3:0] nib;
    nib = 4'($urandom_range(15));
    if (nib >= 4'd10 && $urandom_range(1) == 1) return pctx_pkg::byte_t'("a" + nib - 10);
    return sb.hex_digit(nib);
  endfunction

  function automatic pctx_pkg::byte_t pick_non_hex();
    pctx_pkg::byte_t c;
    do c = pctx_pkg::byte_t'($urandom_range(255));
    while (sb.digit_value(c) != pctx_pkg::HEX_NONE);
    return c;
  endfunction

  // One string: mostly well-formed escapes when decoding, with broken and cut-off ones mixed in
  task automatic send_string(input bit dec);
    string pool;
    pctx_pkg::byte_t esc;
    int n;
    int r;
    bit fin;
    pool = "AMZamz059-_.!~*'()";
    esc = sb.esc_byte;
    n = $urandom_range(1, 6);
    for (int t = 0; t < n; t++) begin
      fin = (t == n - 1);
      r = $urandom_range(99);
      if (!dec) begin
        if (r < 40) send_byte(pctx_pkg::byte_t'(pool[$urandom_range(pool.len() - 1)]), fin);
        else send_byte(pctx_pkg::byte_t'($urandom_range(255)), fin);
      end else if (r < 55) begin
        send_byte(esc, 1'b0);
        send_byte(pick_hex_char(), 1'b0);
        send_byte(pick_hex_char(), fin);
      end else if (r < 70) begin
        send_byte(esc, 1'b0);
        if (r < 60) begin
          send_byte(esc, 1'b0);
          send_byte(pick_hex_char(), fin);
        end else if (r < 65) begin
          send_byte(pick_non_hex(), 1'b0);
          send_byte(pctx_pkg::byte_t'($urandom_range(255)), fin);
        end else begin
          send_byte(pick_hex_char(), 1'b0);
          send_byte(pick_non_hex(), fin);
        end
      end else if (r < 80 && fin) begin
        send_byte(esc, r < 75);
        if (r >= 75) send_byte(pick_hex_char(), 1'b1);
      end else begin
        send_byte(pctx_pkg::byte_t'($urandom_range(255)), fin);
      end
    end
  endtask

  initial begin
    bit dec;
    pctx_pkg::byte_t esc;
    int target;
    int start;
    int settings;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    settings        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode after reset: byte extremes, safe marks, space, the escape itself
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Az9~ %", 1'b1);
    drain();
    write_reg(pctx_pkg::REG_DECODE_MODE, 8'h01);
    write_reg(8'hFF, 8'h55);
    // mixed-case digits, stop after one digit, escape inside capture, cut-off escapes
    send_text("%aF%4g%%7", 1'b0);
    send_text("%c", 1'b1);
    send_text("%", 1'b1);
    // half-captured escape dropped by a register write
    send_text("%4", 1'b0);
    drain();
    write_reg(pctx_pkg::REG_ESCAPE_CHAR, "=");
    send_text("=3D", 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin dec = 1'b1; esc = "%"; end
        1: begin dec = 1'b0; esc = 8'h00; end
        2: begin dec = 1'b1; esc = 8'hFF; end
        3: begin dec = 1'b0; esc = "="; end
        4: begin dec = 1'b1; esc = "="; end
        5: begin dec = 1'b1; esc = pctx_pkg::byte_t'($urandom_range(255)); end
        default: begin dec = 1'b0; esc = pctx_pkg::byte_t'($urandom_range(255)); end
      endcase
      if ($urandom_range(1) == 1) begin
        write_reg(pctx_pkg::REG_DECODE_MODE, {7'($urandom_range(127)), dec});
        write_reg(pctx_pkg::REG_ESCAPE_CHAR, esc);
      end else begin
        write_reg(pctx_pkg::REG_ESCAPE_CHAR, esc);
        write_reg(pctx_pkg::REG_DECODE_MODE, {7'($urandom_range(127)), dec});
      end
      if ($urandom_range(99) < 30)
        write_reg(pctx_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                  pctx_pkg::CFG_DAT_W'($urandom_range(255)));
      settings++;
      sender_steady   = (p == 2 || p == 3);
      receiver_steady = (p == 2);
      target = (p == 3) ? 24 : 34;
      // flood the block while results are held back
      if (p == 3) hold_requests++;
      start = sent_count;
      while (sent_count - start < target) send_string(dec);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (sb.due_bytes.size() != 0) sb.report($sformatf("%0d bytes never came", sb.due_bytes.size()));

    $display("testbench: %0d requests, %0d result bytes compared, %0d register writes",
             sb.requests, sb.compared, sb.writes);
    $display("testbench: encode and decode over %0d escape settings, with a long result stall",
             settings + 2);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: %0d mismatches", sb.errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
